// ===== src/altok_pkg.sv =====
// shared types and constants of the assembler line tokenizer
// result record, result buffer write bundle, kind and error codes
// no dependencies
package altok_pkg;

	// default sizes, handed to the top level parameters
	localparam int DEF_MAX_TOKENS   = 16;
	localparam int DEF_MAX_LINE_LEN = 256;

	// reset value of the line number limit register
	localparam logic [15:0] MAX_LINE_NUM_RESET = 16'd65529;

	// digit accumulator saturation value, always above any 16-bit limit
	localparam logic [16:0] NUM_CAP = 17'd65536;

	// characters with a meaning to the tokenizer
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// result kinds
	typedef enum logic [2:0] {
		KIND_CHAR      = 3'd0,
		KIND_REPLACE   = 3'd1,
		KIND_TOKEN_END = 3'd2,
		KIND_LINE_NUM  = 3'd3,
		KIND_LINE_DONE = 3'd4,
		KIND_ERROR     = 3'd5
	} kind_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_UNTERM     = 3'd0,
		ERR_QUOTE      = 3'd1,
		ERR_NO_SP_SEMI = 3'd2,
		ERR_NO_SP_QUOT = 3'd3,
		ERR_TOO_MANY   = 3'd4,
		ERR_LINE_RANGE = 3'd5
	} err_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_value;
		logic [7:0]  start_offset;
		logic [8:0]  source_length;
		logic [3:0]  token_index;
		logic [15:0] line_value;
		err_t        error_code;
		logic        has_comment;
		logic        last;
	} result_t;

	// results of one accepted item going into the result buffer
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} rq_write_t;

endpackage

// ===== src/altok_outq.sv =====
// two-entry result buffer between the tokenizer and the output channel
// takes up to two results per cycle, presents one per transaction
// depends on altok_pkg
module altok_outq import altok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rq_write_t wr,
	input  logic      take,
	output result_t   head,
	output logic      head_valid,
	output logic      can_take
);

	logic [1:0] cnt_q;
	result_t    slot0_q;
	result_t    slot1_q;

	logic       pop;
	logic [1:0] base;
	result_t    slot0_d;
	result_t    slot1_d;

	assign head       = slot0_q;
	assign head_valid = (cnt_q != 2'd0);
	assign pop        = take && head_valid;
	assign base       = cnt_q - {1'b0, pop};

	// room for two results once the current head leaves
	assign can_take = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

	// shift out the head, then append new results behind what is kept
	always_comb begin
		slot0_d = slot0_q;
		slot1_d = slot1_q;
		if (pop) begin
			slot0_d = slot1_q;
		end
		if (wr.n != 2'd0) begin
			if (base == 2'd0) begin
				slot0_d = wr.r0;
			end else begin
				slot1_d = wr.r0;
			end
		end
		if (wr.n == 2'd2) begin
			slot1_d = wr.r1;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + wr.n;
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

endmodule

// ===== src/assembler_line_tokenizer.sv =====
// top level of the assembler line tokenizer: per-byte state machine and ports
// depends on altok_pkg and altok_outq
//
// Usage:
// - input channel (in_valid/in_ready): one source byte in ch per transaction,
//   or an end-of-line marker with line_end high (ch is then ignored)
// - output channel (out_valid/out_ready): one result per transaction; the
//   last result caused by an input transaction carries last high
// - configuration channel (cfg_valid/cfg_ready/cfg_data): writes the line
//   number limit; always ready; the user must write it only while the
//   block is idle, which the block itself does not enforce
// - an accepted item's results are registered as the tokenizer state advances
// - throughput: one item per cycle while each item causes at most one result
//   and the receiver takes one per cycle; an end of line with a pending token
//   or an open string causes two results, and in_ready drops while the
//   single-result output port drains the two-entry result buffer
// - when the receiver stalls, up to two results wait in the buffer and
//   in_ready drops once the buffer cannot take another item's results
// - reset: state machine at start of token, counters cleared, buffer empty,
//   line number limit back to 65529
module assembler_line_tokenizer import altok_pkg::*; #(
	parameter int MAX_TOKENS   = DEF_MAX_TOKENS,
	parameter int MAX_LINE_LEN = DEF_MAX_LINE_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  char_value,
	output logic [7:0]  start_offset,
	output logic [8:0]  source_length,
	output logic [3:0]  token_index,
	output logic [15:0] line_value,
	output logic [2:0]  error_code,
	output logic        has_comment,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int CLW = $clog2(MAX_LINE_LEN + 1);
	localparam int TCW = $clog2(MAX_TOKENS + 1);
	localparam logic [CLW-1:0] COL_LIMIT = CLW'(MAX_LINE_LEN);
	localparam logic [TCW-1:0] TOK_LIMIT = TCW'(MAX_TOKENS);

	// token character count only needs none, one or more
	localparam logic [1:0] TC_NONE = 2'd0;
	localparam logic [1:0] TC_ONE  = 2'd1;
	localparam logic [1:0] TC_MANY = 2'd2;

	typedef enum logic [2:0] {
		ST_START  = 3'd0,
		ST_STRING = 3'd1,
		ST_TOKEN  = 3'd2,
		ST_ESCAPE = 3'd3,
		ST_NEEDWS = 3'd4,
		ST_END    = 3'd5,
		ST_ERROR  = 3'd6
	} state_t;

	typedef struct packed {
		logic    emit;
		logic    ok;
		logic    inc;
		result_t r;
	} save_t;

	state_t           st_q, st_d;
	logic [CLW-1:0]   col_q, col_d;
	logic [CLW-1:0]   ts_q, ts_d;
	logic [1:0]       tc_q, tc_d;
	logic [TCW-1:0]   cnt_q, cnt_d;
	logic             dig_q, dig_d;
	logic [16:0]      acc_q, acc_d;
	logic             com_q, com_d;
	logic [15:0]      max_line_q;

	logic             accept;
	logic             nl, ws;
	logic             do_push, do_save, do_fail, do_repl;
	err_t             err;
	save_t            sv;
	result_t          r0, r1, done_r;
	logic [1:0]       n;
	logic [20:0]      acc_v;
	rq_write_t        wr;
	result_t          head;
	logic             can_take;

	// widen or cut state values to the result field widths
	function automatic logic [7:0] to_off8(input logic [CLW-1:0] v);
		logic [CLW+7:0] w;
		w = {8'b0, v};
		return w[7:0];
	endfunction

	function automatic logic [8:0] to_len9(input logic [CLW-1:0] v);
		logic [CLW+8:0] w;
		w = {9'b0, v};
		return w[8:0];
	endfunction

	function automatic logic [3:0] to_idx4(input logic [TCW-1:0] v);
		logic [TCW+3:0] w;
		w = {4'b0, v};
		return w[3:0];
	endfunction

	function automatic result_t err_res(input err_t code);
		result_t r;
		r            = '0;
		r.kind       = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	// end the pending token: line number, token end or an error
	function automatic save_t save_fn(
		input logic [1:0]     tc,
		input logic [CLW-1:0] ts,
		input logic [CLW-1:0] col,
		input logic           dig,
		input logic [16:0]    acc,
		input logic [TCW-1:0] cnt,
		input logic [15:0]    maxln
	);
		save_t          s;
		logic [CLW-1:0] len;
		s   = '0;
		len = col - ts;
		s.ok = 1'b1;
		if (tc != TC_NONE) begin
			s.emit = 1'b1;
			if ((ts == '0) && dig) begin
				if (acc > {1'b0, maxln}) begin
					s.ok = 1'b0;
					s.r  = err_res(ERR_LINE_RANGE);
				end else begin
					s.r.kind          = KIND_LINE_NUM;
					s.r.source_length = to_len9(len);
					s.r.line_value    = acc[15:0];
				end
			end else if (cnt < TOK_LIMIT) begin
				s.inc             = 1'b1;
				s.r.kind          = KIND_TOKEN_END;
				s.r.start_offset  = to_off8(ts);
				s.r.source_length = to_len9(len);
				s.r.token_index   = to_idx4(cnt);
			end else begin
				s.ok = 1'b0;
				s.r  = err_res(ERR_TOO_MANY);
			end
		end
		return s;
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = can_take;
	assign cfg_ready = 1'b1;

	assign nl = (ch == CH_LF) || (ch == CH_CR);
	assign ws = nl || (ch == CH_TAB) || (ch == CH_SPACE);

	assign sv    = save_fn(tc_q, ts_q, col_q, dig_q, acc_q, cnt_q, max_line_q);
	assign acc_v = 21'({acc_q, 3'b000}) + 21'({acc_q, 1'b0}) + 21'(ch - CH_ZERO);

	// one tokenizer step for the item at the input
	always_comb begin
		st_d    = st_q;
		col_d   = col_q;
		ts_d    = ts_q;
		tc_d    = tc_q;
		cnt_d   = cnt_q;
		dig_d   = dig_q;
		acc_d   = acc_q;
		com_d   = com_q;
		r0      = '0;
		r1      = '0;
		n       = 2'd0;
		do_push = 1'b0;
		do_save = 1'b0;
		do_fail = 1'b0;
		do_repl = 1'b0;
		err     = ERR_UNTERM;
		done_r  = '0;
		done_r.kind        = KIND_LINE_DONE;
		done_r.has_comment = com_q;

		if (line_end) begin
			// end of line: close what is open, report line done, start over
			case (st_q)
				ST_STRING, ST_ESCAPE: begin
					do_fail = 1'b1;
				end
				ST_TOKEN, ST_NEEDWS: begin
					do_save = 1'b1;
				end
				default: begin
				end
			endcase
			if (do_fail) begin
				r0 = err_res(ERR_UNTERM);
				r1 = done_r;
				n  = 2'd2;
			end else if (do_save && sv.emit) begin
				r0 = sv.r;
				r1 = done_r;
				n  = 2'd2;
			end else begin
				r0 = done_r;
				n  = 2'd1;
			end
			st_d  = ST_START;
			col_d = '0;
			ts_d  = '0;
			cnt_d = '0;
			com_d = 1'b0;
			tc_d  = TC_NONE;
			dig_d = 1'b1;
			acc_d = '0;
		end else begin
			// byte: state transitions
			case (st_q)
				ST_START: begin
					if (ch == CH_SEMI) begin
						com_d = 1'b1;
						st_d  = ST_END;
					end else if (ch == CH_QUOTE) begin
						do_push = 1'b1;
						st_d    = ST_STRING;
					end else if (!ws) begin
						do_push = 1'b1;
						st_d    = ST_TOKEN;
					end
				end
				ST_STRING: begin
					if (ch == CH_BSLASH) begin
						do_push = 1'b1;
						st_d    = ST_ESCAPE;
					end else if (ch == CH_QUOTE) begin
						do_push = 1'b1;
						st_d    = ST_NEEDWS;
					end else if (nl) begin
						do_fail = 1'b1;
						err     = ERR_UNTERM;
					end else begin
						do_push = 1'b1;
					end
				end
				ST_TOKEN: begin
					if (ch == CH_QUOTE) begin
						do_fail = 1'b1;
						err     = ERR_QUOTE;
					end else if (ch == CH_SEMI) begin
						do_fail = 1'b1;
						err     = ERR_NO_SP_SEMI;
					end else if (ws) begin
						do_save = 1'b1;
					end else begin
						do_push = 1'b1;
					end
				end
				ST_ESCAPE: begin
					if (ch == CH_QUOTE) begin
						do_repl = 1'b1;
						st_d    = ST_STRING;
					end else if (nl) begin
						do_fail = 1'b1;
						err     = ERR_UNTERM;
					end else begin
						do_push = 1'b1;
						st_d    = ST_STRING;
					end
				end
				ST_NEEDWS: begin
					if (ws) begin
						do_save = 1'b1;
					end else begin
						do_fail = 1'b1;
						err     = ERR_NO_SP_QUOT;
					end
				end
				default: begin
				end
			endcase

			// append a character to the token
			if (do_push) begin
				if (tc_q == TC_NONE) begin
					tc_d = TC_ONE;
					ts_d = col_q;
				end else begin
					tc_d = TC_MANY;
				end
				if ((ch >= CH_ZERO) && (ch <= CH_NINE)) begin
					acc_d = (acc_v > 21'(NUM_CAP)) ? NUM_CAP : acc_v[16:0];
				end else begin
					dig_d = 1'b0;
				end
				r0.kind         = KIND_CHAR;
				r0.char_value   = ch;
				r0.start_offset = to_off8((tc_q == TC_NONE) ? col_q : ts_q);
				r0.token_index  = to_idx4(cnt_q);
				n               = 2'd1;
			end

			// escaped quote overwrites the backslash
			if (do_repl) begin
				r0.kind         = KIND_REPLACE;
				r0.char_value   = CH_QUOTE;
				r0.start_offset = to_off8(ts_q);
				r0.token_index  = to_idx4(cnt_q);
				n               = 2'd1;
			end

			// whitespace after a token
			if (do_save) begin
				if (sv.emit) begin
					r0 = sv.r;
					n  = 2'd1;
				end
				if (sv.ok) begin
					st_d  = ST_START;
					tc_d  = TC_NONE;
					dig_d = 1'b1;
					acc_d = '0;
					if (sv.inc) begin
						cnt_d = cnt_q + TCW'(1);
					end
				end else begin
					st_d = ST_ERROR;
				end
			end

			if (do_fail) begin
				r0   = err_res(err);
				n    = 2'd1;
				st_d = ST_ERROR;
			end

			// column saturates at the line length bound
			if (col_q < COL_LIMIT) begin
				col_d = col_q + CLW'(1);
			end
		end

		// mark the final result of this item
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end else if (n == 2'd1) begin
			r0.last = 1'b1;
		end
	end

	// tokenizer state and line number limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_START;
			col_q      <= '0;
			ts_q       <= '0;
			tc_q       <= TC_NONE;
			cnt_q      <= '0;
			dig_q      <= 1'b1;
			acc_q      <= '0;
			com_q      <= 1'b0;
			max_line_q <= MAX_LINE_NUM_RESET;
		end else begin
			if (accept) begin
				st_q  <= st_d;
				col_q <= col_d;
				ts_q  <= ts_d;
				tc_q  <= tc_d;
				cnt_q <= cnt_d;
				dig_q <= dig_d;
				acc_q <= acc_d;
				com_q <= com_d;
			end
			if (cfg_valid) begin
				max_line_q <= cfg_data;
			end
		end
	end

	// results into the buffer only on an input transaction
	always_comb begin
		wr    = '0;
		wr.r0 = r0;
		wr.r1 = r1;
		wr.n  = accept ? n : 2'd0;
	end

	altok_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.take       (out_ready),
		.head       (head),
		.head_valid (out_valid),
		.can_take   (can_take)
	);

	// output fields
	assign kind          = head.kind;
	assign char_value    = head.char_value;
	assign start_offset  = head.start_offset;
	assign source_length = head.source_length;
	assign token_index   = head.token_index;
	assign line_value    = head.line_value;
	assign error_code    = head.error_code;
	assign has_comment   = head.has_comment;
	assign last          = head.last;

endmodule
